@@ src/pgd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgd_pkg
// Shared types, constants and helpers of the gray palette dither converter.
// ----------------------------------------------------------------------------
package pgd_pkg;

    // Palette depth and address width
    localparam int PAL_ENTRIES = 256;
    localparam int PAL_AW      = $clog2(PAL_ENTRIES);
    localparam logic [8:0] PAL_LIMIT = 9'(PAL_ENTRIES);

    // Item kinds
    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_INDEX = 2'd1,
        MODE_RGB   = 2'd2
    } t_mode;

    // Indexed pixel thresholds on the weighted sum 30R+59G+11B, i.e. 100x the
    // luminance levels 70, 128 and 192.
    localparam logic [14:0] PAL_TH3 = 15'd7000;
    localparam logic [14:0] PAL_TH2 = 15'd12800;
    localparam logic [14:0] PAL_TH1 = 15'd19200;

    // Raw index used as luminance
    localparam logic [7:0] IDX_TH3 = 8'd70;
    localparam logic [7:0] IDX_TH2 = 8'd128;
    localparam logic [7:0] IDX_TH1 = 8'd192;

    // RGB555 thresholds on the weighted sum s: s*255/3100 < T  <=>  s < ceil(3100*T/255)
    localparam logic [11:0] RGB_TH3 = 12'd851;
    localparam logic [11:0] RGB_TH2 = 12'd1557;
    localparam logic [11:0] RGB_TH1 = 12'd2335;

    // Palette entry
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // Pixel held between the input register and the result register
    typedef struct packed {
        logic        is_rgb;
        logic        outside;
        logic [14:0] pixel_value;
        logic [2:0]  x_lo;
        logic [2:0]  y_lo;
    } t_pix;

    // Pack a gray level as RGB565 with v = (3 - level) * 85
    function automatic logic [15:0] pack565(input logic [1:0] level);
        logic [4:0] v5;
        logic [5:0] v6;
        unique case (level)
            2'd0: begin v5 = 5'd31; v6 = 6'd63; end
            2'd1: begin v5 = 5'd21; v6 = 6'd42; end
            2'd2: begin v5 = 5'd10; v6 = 6'd21; end
            default: begin v5 = 5'd0; v6 = 6'd0; end
        endcase
        return {v5, v6, v5};
    endfunction

endpackage

@@ src/pgd_palette.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgd_palette
// Palette memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pgd_palette
    import pgd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [PAL_AW-1:0] i_waddr,
    input  t_rgb              i_wdata,
    input  logic              i_re,
    input  logic [PAL_AW-1:0] i_raddr,
    output t_rgb              o_rdata
);

    t_rgb r_mem [PAL_ENTRIES];
    t_rgb r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold read data until the next pixel transfer
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/pgd_shade.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgd_shade
// Luminance, four-level quantization, ordered dither and RGB565 packing.
// ----------------------------------------------------------------------------
module pgd_shade
    import pgd_pkg::*;
(
    input  t_pix        i_pix,
    input  t_rgb        i_entry,
    input  logic        i_palette_enabled,
    output logic [15:0] o_color,
    output logic [1:0]  o_level
);

    logic [14:0] pal_sum;
    logic [11:0] rgb_sum;
    logic [4:0]  r5, g5, b5;
    logic [7:0]  idx;
    logic        idx_ok;
    logic [1:0]  base_level;
    logic [1:0]  level;
    logic [2:0]  dith_a;
    logic [2:0]  dith_b;

    assign idx    = i_pix.pixel_value[7:0];
    assign idx_ok = {1'b0, idx} < PAL_LIMIT;
    assign r5     = i_pix.pixel_value[14:10];
    assign g5     = i_pix.pixel_value[9:5];
    assign b5     = i_pix.pixel_value[4:0];

    assign pal_sum = 15'(i_entry.red) * 15'd30 + 15'(i_entry.green) * 15'd59
                   + 15'(i_entry.blue) * 15'd11;
    assign rgb_sum = 12'(r5) * 12'd30 + 12'(g5) * 12'd59 + 12'(b5) * 12'd11;

    // Dither phases: (x + 3y) mod 4 and (3x + y) mod 8
    assign dith_a = i_pix.x_lo + 3'(i_pix.y_lo * 3'd3);
    assign dith_b = 3'(i_pix.x_lo * 3'd3) + i_pix.y_lo;

    always_comb begin
        if (i_pix.is_rgb) begin
            if (rgb_sum < RGB_TH3)      base_level = 2'd3;
            else if (rgb_sum < RGB_TH2) base_level = 2'd2;
            else if (rgb_sum < RGB_TH1) base_level = 2'd1;
            else                        base_level = 2'd0;
        end else if (!i_palette_enabled) begin
            if (idx < IDX_TH3)      base_level = 2'd3;
            else if (idx < IDX_TH2) base_level = 2'd2;
            else if (idx < IDX_TH1) base_level = 2'd1;
            else                    base_level = 2'd0;
        end else if (!idx_ok) begin
            base_level = 2'd3;
        end else begin
            if (pal_sum < PAL_TH3)      base_level = 2'd3;
            else if (pal_sum < PAL_TH2) base_level = 2'd2;
            else if (pal_sum < PAL_TH1) base_level = 2'd1;
            else                        base_level = 2'd0;
        end
    end

    always_comb begin
        level = base_level;
        if (!i_pix.is_rgb) begin
            if (base_level == 2'd2 && dith_a[1:0] == 2'd0) begin
                level = 2'd1;
            end else if (base_level == 2'd1 && dith_b == 3'd0) begin
                level = 2'd2;
            end
        end
    end

    assign o_level = i_pix.outside ? 2'd3  : level;
    assign o_color = i_pix.outside ? 16'd0 : pack565(level);

endmodule

@@ src/palette_gray_dither_rgb565.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_gray_dither_rgb565
// Four-level gray converter with ordered dither and RGB565 output.
// ----------------------------------------------------------------------------
// Pipeline: a pixel transfer passes the palette read register, then the
//   result register.
// Throughput: one item per cycle unless back-pressure holds the input; the
//   single read port is used once per pixel, the write port once per load.
// Reset: clears both stage valids and sets palette_enabled to 1. Palette
//   contents are undefined until written; there is no clearing pass.
// ----------------------------------------------------------------------------
module palette_gray_dither_rgb565
    import pgd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_entry_index,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [14:0] i_pixel_value,
    input  logic [9:0]  i_screen_x,
    input  logic [9:0]  i_screen_y,
    input  logic        i_outside,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_color,
    output logic [1:0]  o_gray_level
);

    logic        r_palette_enabled;

    // Stage 1: pixel fields beside the registered palette read
    logic        r_s1_valid;
    t_pix        r_s1_pix;
    // Stage 2: result register
    logic        r_s2_valid;
    logic [15:0] r_s2_color;
    logic [1:0]  r_s2_level;

    logic        in_xfer;
    logic        is_load;
    logic        is_pixel;
    logic        pix_xfer;
    logic        load_we;
    logic        s2_open;
    logic        s1_move;
    t_pix        n_s1_pix;
    t_rgb        wr_entry;
    t_rgb        rd_entry;
    logic [15:0] shade_color;
    logic [1:0]  shade_level;

    // The result register frees up when empty or when its result transfers;
    // stage 1 moves on whenever the result register is free.
    assign s2_open = !r_s2_valid || !i_stall;
    assign s1_move = r_s1_valid && s2_open;
    assign o_stall = r_s1_valid && !s2_open;

    assign in_xfer  = i_valid && !o_stall;
    assign is_load  = (i_mode == MODE_LOAD);
    assign is_pixel = (i_mode == MODE_INDEX) || (i_mode == MODE_RGB);
    assign pix_xfer = in_xfer && is_pixel;
    // Drop loads aimed past the end of the palette
    assign load_we  = in_xfer && is_load && ({1'b0, i_entry_index} < PAL_LIMIT);

    assign wr_entry = '{red: i_red, green: i_green, blue: i_blue};

    assign n_s1_pix = '{
        is_rgb:      (i_mode == MODE_RGB),
        outside:     i_outside,
        pixel_value: i_pixel_value,
        x_lo:        i_screen_x[2:0],
        y_lo:        i_screen_y[2:0]
    };

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette_enabled <= 1'b1;
        end else if (i_cfg_we) begin
            r_palette_enabled <= i_cfg_wdata;
        end
    end

    // Read the palette on every pixel transfer; an RGB pixel ignores the data
    pgd_palette u_palette (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (i_entry_index[PAL_AW-1:0]),
        .i_wdata (wr_entry),
        .i_re    (pix_xfer),
        .i_raddr (i_pixel_value[PAL_AW-1:0]),
        .o_rdata (rd_entry)
    );

    // Stage 1 control: load items and unused modes leave no entry behind
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= is_pixel;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_xfer) begin
            r_s1_pix <= n_s1_pix;
        end
    end

    pgd_shade u_shade (
        .i_pix             (r_s1_pix),
        .i_entry           (rd_entry),
        .i_palette_enabled (r_palette_enabled),
        .o_color           (shade_color),
        .o_level           (shade_level)
    );

    // Result register: advance on stage 1 move, clear once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_open) begin
            r_s2_valid <= s1_move;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s2_color <= shade_color;
            r_s2_level <= shade_level;
        end
    end

    assign o_valid      = r_s2_valid;
    assign o_color      = r_s2_color;
    assign o_gray_level = r_s2_level;

    // A load transfer never leaves an item in stage 1
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && is_load |=> !r_s1_valid)
        else $error("load item entered the pixel pipe");

    // A pixel transfer always lands in stage 1
    a_pixel_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix_xfer |=> r_s1_valid)
        else $error("pixel item lost at stage 1");

    // Back-pressure only with both stages full and the output stalled
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_s1_valid && r_s2_valid && i_stall)
        else $error("input stalled with room in the pipe");

    // A stage 1 item blocked at the result register stays put
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s2_open |=> r_s1_valid && $stable(r_s1_pix))
        else $error("stage 1 item changed while blocked");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the four-level gray dither converter.
// Streams palette loads, indexed pixels and RGB555 pixels into the block and
// predicts every gray result from a bench-side copy of the palette and the
// enable bit. Results are checked in order, field by field, while both
// channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tb_top;
    import pgd_pkg::*;

    // Mode code 3 carries no meaning and must be dropped by the block
    localparam logic [1:0] MODE_SKIP = 2'd3;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 3;
    // Pixel results pass stage 1 and the result register; give some margin
    localparam int DRAIN_CYCLES = 6;
    // Cycles without any transfer before the run is declared hung
    localparam int HANG_LIMIT   = 2000;
    localparam int REPORT_MAX   = 10;

    // Luminance boundaries between the four gray levels
    localparam int LUM_DARK  = 70;
    localparam int LUM_MID   = 128;
    localparam int LUM_LIGHT = 192;

    // One input transfer, every field as it goes onto the ports
    typedef struct {
        logic [1:0]  mode;
        logic [7:0]  entry_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [14:0] pixel_value;
        logic [9:0]  sx;
        logic [9:0]  sy;
        logic        outside;
    } t_pix_item;

    // One output transfer
    typedef struct {
        logic [15:0] color;
        logic [1:0]  gray_level;
    } t_gray_out;

    // ------------------------------------------------------------------
    // Block ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_wdata   = 1'b0;
    logic        i_valid       = 1'b0;
    logic        o_stall;
    logic [1:0]  i_mode        = '0;
    logic [7:0]  i_entry_index = '0;
    logic [7:0]  i_red         = '0;
    logic [7:0]  i_green       = '0;
    logic [7:0]  i_blue        = '0;
    logic [14:0] i_pixel_value = '0;
    logic [9:0]  i_screen_x    = '0;
    logic [9:0]  i_screen_y    = '0;
    logic        i_outside     = 1'b0;
    logic        o_valid;
    logic        i_stall       = 1'b0;
    logic [15:0] o_color;
    logic [1:0]  o_gray_level;

    palette_gray_dither_rgb565 u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_mode        (i_mode),
        .i_entry_index (i_entry_index),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_pixel_value (i_pixel_value),
        .i_screen_x    (i_screen_x),
        .i_screen_y    (i_screen_y),
        .i_outside     (i_outside),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_color       (o_color),
        .o_gray_level  (o_gray_level)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    t_pix_item  pending_q[$];          // items waiting for the driver
    t_gray_out  gray_exp_q[$];         // predicted results, oldest first
    t_rgb       pal_copy[PAL_ENTRIES]; // palette as the block should hold it
    bit         pal_on_copy = 1'b1;    // palette_enabled after reset is 1

    // Entries already scheduled for a load, in stimulus order. Indexed pixels
    // with the palette on only look up entries from this list, so no unwritten entry feeds a result.
    bit         pal_loaded[PAL_ENTRIES];
    logic [7:0] loaded_idx_q[$];

    int  err_count   = 0;
    bit  no_idle     = 1'b0;  // set for the closing stretch of the run
    int  src_gap     = 0;
    int  src_pct     = 0;
    int  src_left    = 0;
    int  snk_gap     = 0;
    int  snk_pct     = 0;
    int  snk_left    = 0;
    int  hang_cycles = 0;
    t_pix_item drv_item;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Gray predictor: luminance, four-level quantization, ordered dither
    // for indexed pixels only, then RGB565 packing.
    // ------------------------------------------------------------------
    function automatic t_gray_out predict_gray(t_pix_item it);
        t_rgb        e;
        logic [14:0] wsum;
        logic [19:0] scaled;
        logic [4:0]  r5, g5, b5;
        logic [7:0]  lum;
        logic [1:0]  lvl;
        logic [7:0]  v;
        t_gray_out   res;
        // Pixels outside the content are black, darkest level
        if (it.outside) begin
            res.color      = '0;
            res.gray_level = 2'd3;
            return res;
        end
        if (it.mode == MODE_INDEX) begin
            if (pal_on_copy) begin
                e    = pal_copy[it.pixel_value[7:0]];
                wsum = 15'(30 * e.red + 59 * e.green + 11 * e.blue);
                lum  = 8'(wsum / 100);
            end else begin
                // palette off: the index is the luminance, upper bits ignored
                lum = it.pixel_value[7:0];
            end
        end else begin
            r5     = it.pixel_value[14:10];
            g5     = it.pixel_value[9:5];
            b5     = it.pixel_value[4:0];
            scaled = 20'((30 * r5 + 59 * g5 + 11 * b5) * 255);
            lum    = 8'(scaled / 3100);
        end
        if (lum < LUM_DARK)       lvl = 2'd3;
        else if (lum < LUM_MID)   lvl = 2'd2;
        else if (lum < LUM_LIGHT) lvl = 2'd1;
        else                      lvl = 2'd0;
        // Ordered dither swaps the two middle levels on a position pattern
        if (it.mode == MODE_INDEX) begin
            if (lvl == 2'd2 && ((int'(it.sx) + 3 * int'(it.sy)) % 4) == 0)
                lvl = 2'd1;
            else if (lvl == 2'd1 && ((3 * int'(it.sx) + int'(it.sy)) % 8) == 0)
                lvl = 2'd2;
        end
        v              = 8'((3 - lvl) * 85);
        res.color      = {v[7:3], v[7:2], v[7:3]};
        res.gray_level = lvl;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    // Every field random, so unused fields toggle too
    function automatic t_pix_item rand_item();
        t_pix_item it;
        it.mode        = 2'($urandom_range(0, 3));
        it.entry_index = 8'($urandom);
        it.red         = 8'($urandom);
        it.green       = 8'($urandom);
        it.blue        = 8'($urandom);
        it.pixel_value = 15'($urandom);
        it.sx          = 10'($urandom);
        it.sy          = 10'($urandom);
        it.outside     = ($urandom_range(0, 9) == 0);
        return it;
    endfunction

    function automatic void push_item(t_pix_item it);
        if (it.mode == MODE_LOAD && !pal_loaded[it.entry_index]) begin
            pal_loaded[it.entry_index] = 1'b1;
            loaded_idx_q.push_back(it.entry_index);
        end
        pending_q.push_back(it);
    endfunction

    function automatic void push_load(logic [7:0] idx, logic [7:0] r,
                                      logic [7:0] g, logic [7:0] b);
        t_pix_item it;
        it             = rand_item();
        it.mode        = MODE_LOAD;
        it.entry_index = idx;
        it.red         = r;
        it.green       = g;
        it.blue        = b;
        push_item(it);
    endfunction

    function automatic void push_pixel(logic [1:0] mode, logic [14:0] pv,
                                       logic [9:0] x, logic [9:0] y, logic out);
        t_pix_item it;
        it             = rand_item();
        it.mode        = mode;
        it.pixel_value = pv;
        it.sx          = x;
        it.sy          = y;
        it.outside     = out;
        push_item(it);
    endfunction

    // Random mix; with the palette on, indexed pixels only hit loaded entries
    function automatic void push_random(bit pal_on, int load_pct);
        t_pix_item it;
        int        pick;
        it   = rand_item();
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            it.mode = MODE_SKIP;
        end else if (pick < 3 + load_pct) begin
            it.mode = MODE_LOAD;
            // gray entries land on the exact level boundaries now and then
            if ($urandom_range(0, 3) == 0) begin
                it.green = it.red;
                it.blue  = it.red;
            end
        end else if ($urandom_range(0, 1) == 0) begin
            it.mode = MODE_INDEX;
            if (pal_on)
                it.pixel_value[7:0] =
                    loaded_idx_q[$urandom_range(0, loaded_idx_q.size() - 1)];
        end else begin
            it.mode = MODE_RGB;
        end
        push_item(it);
    endfunction

    function automatic int pick_idle_pct();
        unique case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 35;
        endcase
    endfunction

    // Hold until the queue is drained and every expected result has come,
    // then let the pipeline settle behind any trailing load transfer
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (pending_q.size() != 0 || i_valid || gray_exp_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_pal_enable(bit val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        pal_on_copy  = val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: present the next pending item, hold it while stalled
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            src_gap  = 0;
        end else begin
            if (i_valid && !o_stall) begin
                // transfer done: update the palette copy or predict the pixel
                if (drv_item.mode == MODE_LOAD)
                    pal_copy[drv_item.entry_index] =
                        {drv_item.red, drv_item.green, drv_item.blue};
                else if (drv_item.mode != MODE_SKIP)
                    gray_exp_q.push_back(predict_gray(drv_item));
                if (src_left <= 0) begin
                    src_pct  = pick_idle_pct();
                    src_left = $urandom_range(20, 80);
                end
                src_left--;
                if (!no_idle && $urandom_range(0, 99) < src_pct)
                    src_gap = $urandom_range(1, 4);
            end
            if (!i_valid || !o_stall) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_valid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    drv_item       = pending_q.pop_front();
                    i_mode        <= drv_item.mode;
                    i_entry_index <= drv_item.entry_index;
                    i_red         <= drv_item.red;
                    i_green       <= drv_item.green;
                    i_blue        <= drv_item.blue;
                    i_pixel_value <= drv_item.pixel_value;
                    i_screen_x    <= drv_item.sx;
                    i_screen_y    <= drv_item.sy;
                    i_outside     <= drv_item.outside;
                    i_valid       <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each result transfer, drive output stall bursts
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_gray_out want;
        bit        hold;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (gray_exp_q.size() == 0) begin
                    err_count++;
                    if (err_count <= REPORT_MAX)
                        $display("ERROR: unexpected result color=%h level=%0d",
                                 o_color, o_gray_level);
                end else begin
                    want = gray_exp_q.pop_front();
                    if (o_color !== want.color || o_gray_level !== want.gray_level) begin
                        err_count++;
                        if (err_count <= REPORT_MAX)
                            $display("ERROR: expected color=%h level=%0d, got color=%h level=%0d",
                                     want.color, want.gray_level, o_color, o_gray_level);
                    end
                end
            end
            if (snk_left <= 0) begin
                snk_pct  = pick_idle_pct();
                snk_left = $urandom_range(20, 80);
            end
            snk_left--;
            if (snk_gap > 0) begin
                snk_gap--;
                hold = 1'b1;
            end else if (!no_idle && $urandom_range(0, 99) < snk_pct) begin
                // stall now and keep stalling while snk_gap counts down
                snk_gap = $urandom_range(0, 3);
                hold    = 1'b1;
            end else begin
                hold = 1'b0;
            end
            i_stall <= hold;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: the longest correct stretch without a transfer is a few
    // bursts plus pipeline latency and a settle pause; the limit is far above
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            hang_cycles = 0;
        end else begin
            hang_cycles++;
            if (hang_cycles >= HANG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed items, then random phases with the palette
    // on, off and on again
    // ------------------------------------------------------------------
    initial begin
        int sweep[PAL_ENTRIES];
        int j;
        int tmp;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Phase A: palette on from reset. Gray entries whose luminance sits
        // on each side of every level boundary, plus black and white.
        push_load(8'd0,   8'd0,   8'd0,   8'd0);
        push_load(8'd255, 8'd255, 8'd255, 8'd255);
        push_load(8'd69,  8'd69,  8'd69,  8'd69);
        push_load(8'd70,  8'd70,  8'd70,  8'd70);
        push_load(8'd127, 8'd127, 8'd127, 8'd127);
        push_load(8'd128, 8'd128, 8'd128, 8'd128);
        push_load(8'd191, 8'd191, 8'd191, 8'd191);
        push_load(8'd192, 8'd192, 8'd192, 8'd192);
        push_pixel(MODE_INDEX, 15'd0,   10'd0,    10'd0,    1'b0);
        push_pixel(MODE_INDEX, 15'd255, 10'd1023, 10'd1023, 1'b0);
        push_pixel(MODE_INDEX, 15'd69,  10'd5,    10'd1,    1'b0);
        push_pixel(MODE_INDEX, 15'd70,  10'd1,    10'd0,    1'b0);
        // dither: level 2 turns into 1, level 1 into 2, and neither off-grid
        push_pixel(MODE_INDEX, 15'd127, 10'd0,    10'd0,    1'b0);
        push_pixel(MODE_INDEX, 15'd127, 10'd2,    10'd0,    1'b0);
        push_pixel(MODE_INDEX, 15'd128, 10'd0,    10'd0,    1'b0);
        push_pixel(MODE_INDEX, 15'd128, 10'd1,    10'd0,    1'b0);
        push_pixel(MODE_INDEX, 15'd191, 10'd1023, 10'd1023, 1'b0);
        push_pixel(MODE_INDEX, 15'd192, 10'd1023, 10'd0,    1'b0);
        // upper index bits are ignored in indexed mode
        push_pixel(MODE_INDEX, {7'h7F, 8'd70}, 10'd1, 10'd0, 1'b0);
        // pixels outside the content
        push_pixel(MODE_INDEX, 15'd255,   10'd0, 10'd0, 1'b1);
        push_pixel(MODE_RGB,   15'h7FFF,  10'd0, 10'd0, 1'b1);
        // RGB555: black, white, pure channels; no dither even on the grid
        push_pixel(MODE_RGB, 15'h0000, 10'd0,    10'd0, 1'b0);
        push_pixel(MODE_RGB, 15'h7FFF, 10'd1023, 10'd0, 1'b0);
        push_pixel(MODE_RGB, 15'h7C00, 10'd0,    10'd0, 1'b0);
        push_pixel(MODE_RGB, 15'h03E0, 10'd0,    10'd0, 1'b0);
        push_pixel(MODE_RGB, 15'h001F, 10'd0,    10'd1023, 1'b0);
        // unused mode must be dropped
        push_pixel(MODE_SKIP, 15'h7FFF, 10'd0, 10'd0, 1'b0);
        wait_idle();

        // Phase B: palette on, written explicitly. Load every entry in
        // shuffled order with pixels in between, then a random mix.
        write_pal_enable(1'b1);
        for (int k = 0; k < PAL_ENTRIES; k++)
            sweep[k] = k;
        for (int k = PAL_ENTRIES - 1; k > 0; k--) begin
            j        = $urandom_range(0, k);
            tmp      = sweep[k];
            sweep[k] = sweep[j];
            sweep[j] = tmp;
        end
        for (int k = 0; k < PAL_ENTRIES; k++) begin
            push_load(8'(sweep[k]), 8'($urandom), 8'($urandom), 8'($urandom));
            if ($urandom_range(0, 1) == 0)
                push_random(1'b1, 0);
        end
        repeat (200) push_random(1'b1, 15);
        wait_idle();

        // Phase C: palette off, the index is the luminance
        write_pal_enable(1'b0);
        push_pixel(MODE_INDEX, 15'd0,   10'($urandom), 10'($urandom), 1'b0);
        push_pixel(MODE_INDEX, 15'd69,  10'($urandom), 10'($urandom), 1'b0);
        push_pixel(MODE_INDEX, 15'd70,  10'($urandom), 10'($urandom), 1'b0);
        push_pixel(MODE_INDEX, 15'd127, 10'd0,         10'd0,         1'b0);
        push_pixel(MODE_INDEX, 15'd128, 10'd0,         10'd0,         1'b0);
        push_pixel(MODE_INDEX, 15'd191, 10'($urandom), 10'($urandom), 1'b0);
        push_pixel(MODE_INDEX, 15'd192, 10'($urandom), 10'($urandom), 1'b0);
        push_pixel(MODE_INDEX, {7'h7F, 8'd255}, 10'd1023, 10'd1023, 1'b0);
        repeat (300) push_random(1'b0, 10);
        wait_idle();

        // Phase D: palette back on; the closing stretch runs without idling
        write_pal_enable(1'b1);
        repeat (150) push_random(1'b1, 10);
        do
            @(negedge i_clk);
        while (pending_q.size() != 0);
        no_idle = 1'b1;
        repeat (100) push_random(1'b1, 10);

        // Drain, then keep watching for stray results while the pipe settles
        wait_idle();

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
